@@ hw/rtl/b2h_pkg.sv @@
// Shared types and constants of the BGR to HSV pixel unit.
// Used by every module under hw/rtl; depends on nothing.
package b2h_pkg;

  // Channel and numerator widths.
  localparam int unsigned B2H_PIX_W = 8;
  localparam int unsigned B2H_NUM_W = 16;

  // One quotient bit is resolved in each divider stage.
  localparam int unsigned B2H_DIV_STAGES = 8;

  // Two front-end stages, the divider stages and one rounding stage.
  localparam int unsigned B2H_LATENCY = B2H_DIV_STAGES + 3;

  // One divider lane: partial remainder, divisor and quotient bits so far.
  typedef struct packed {
    logic [B2H_NUM_W-1:0] rem;
    logic [B2H_PIX_W-1:0] den;
    logic [B2H_PIX_W-1:0] quo;
  } b2h_lane_t;

  // Side information that travels with each pixel through the pipeline.
  typedef struct packed {
    logic                 valid;
    logic                 hue_zero;
    logic                 sat_zero;
    logic [B2H_PIX_W-1:0] value;
  } b2h_ctrl_t;

endpackage

@@ hw/rtl/b2h_prep.sv @@
// Front end of the BGR to HSV pixel unit: maximum, minimum, sector and
// the numerators of both divisions, over two register stages. Uses b2h_pkg.
module b2h_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [7:0]        blue_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        red_i,
  output b2h_pkg::b2h_ctrl_t ctrl_o,
  output b2h_pkg::b2h_lane_t hue_lane_o,
  output b2h_pkg::b2h_lane_t sat_lane_o
);
  import b2h_pkg::*;

  // Which channel holds the maximum.
  localparam logic [1:0] SECT_RED   = 2'd0;
  localparam logic [1:0] SECT_GREEN = 2'd1;
  localparam logic [1:0] SECT_BLUE  = 2'd2;

  localparam logic [7:0] HUE_OFS_GREEN = 8'd60;
  localparam logic [7:0] HUE_OFS_BLUE  = 8'd120;
  localparam logic [7:0] HUE_OFS_WRAP  = 8'd180;

  logic [7:0]        max_c, min_c;
  logic [1:0]        sect_c;
  logic signed [8:0] diff_c;

  logic              a_valid_q;
  logic [7:0]        a_max_q, a_delta_q;
  logic [1:0]        a_sect_q;
  logic signed [8:0] a_diff_q;

  logic [7:0]         ofs_c;
  logic [15:0]        base_c;
  logic signed [17:0] prod_c, num_c;

  b2h_ctrl_t ctrl_q;
  b2h_lane_t hue_lane_q, sat_lane_q;

  // Stage A: pick the maximum with red over green over blue on ties.
  always_comb begin
    min_c = blue_i;
    if (green_i < min_c) min_c = green_i;
    if (red_i < min_c) min_c = red_i;
    if (red_i >= green_i && red_i >= blue_i) begin
      sect_c = SECT_RED;
      max_c  = red_i;
      diff_c = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i >= blue_i) begin
      sect_c = SECT_GREEN;
      max_c  = green_i;
      diff_c = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sect_c = SECT_BLUE;
      max_c  = blue_i;
      diff_c = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_max_q   <= max_c;
    a_delta_q <= max_c - min_c;
    a_sect_q  <= sect_c;
    a_diff_q  <= diff_c;
  end

  // Stage B: hue numerator is 30 times the difference plus the sector
  // offset times delta; a negative red-sector hue wraps by 180.
  always_comb begin
    case (a_sect_q)
      SECT_RED:   ofs_c = a_diff_q[8] ? HUE_OFS_WRAP : 8'd0;
      SECT_GREEN: ofs_c = HUE_OFS_GREEN;
      SECT_BLUE:  ofs_c = HUE_OFS_BLUE;
      default:    ofs_c = 8'd0;
    endcase
    base_c = 16'(ofs_c) * 16'(a_delta_q);
    prod_c = 18'(a_diff_q) * 18'sd30;
    num_c  = $signed({2'b00, base_c}) + prod_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q.valid    <= a_valid_q;
      ctrl_q.hue_zero <= (a_delta_q == 8'd0);
      ctrl_q.sat_zero <= (a_max_q == 8'd0);
      ctrl_q.value    <= a_max_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_lane_q.rem <= num_c[15:0];
    hue_lane_q.den <= a_delta_q;
    hue_lane_q.quo <= '0;
    // 255 * delta as a shift and a subtract.
    sat_lane_q.rem <= {a_delta_q, 8'd0} - {8'd0, a_delta_q};
    sat_lane_q.den <= a_max_q;
    sat_lane_q.quo <= '0;
  end

  assign ctrl_o     = ctrl_q;
  assign hue_lane_o = hue_lane_q;
  assign sat_lane_o = sat_lane_q;

endmodule

@@ hw/rtl/b2h_div_step.sv @@
// One registered step of the restoring divider: resolves one quotient bit.
// Uses b2h_pkg for the lane type.
module b2h_div_step (
  input  logic               clk_i,
  input  b2h_pkg::b2h_lane_t lane_i,
  output b2h_pkg::b2h_lane_t lane_o
);
  import b2h_pkg::*;

  logic [15:0] dvs_c, sub_c;
  logic        fit_c;
  b2h_lane_t   lane_d, lane_q;

  // The divisor sits at bit 7; the remainder shifts up one place a step,
  // so after eight steps it holds 256 times the true remainder.
  always_comb begin
    dvs_c  = {1'b0, lane_i.den, 7'd0};
    fit_c  = (lane_i.rem >= dvs_c);
    sub_c  = fit_c ? (lane_i.rem - dvs_c) : lane_i.rem;
    lane_d.rem = {sub_c[14:0], 1'b0};
    lane_d.den = lane_i.den;
    lane_d.quo = {lane_i.quo[6:0], fit_c};
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

@@ hw/rtl/b2h_round.sv @@
// Output stage: rounds both quotients to nearest, ties to even, forces the
// gray and black special cases and registers the result. Uses b2h_pkg.
module b2h_round (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  b2h_pkg::b2h_ctrl_t ctrl_i,
  input  b2h_pkg::b2h_lane_t hue_lane_i,
  input  b2h_pkg::b2h_lane_t sat_lane_i,
  output logic               done_o,
  output logic [7:0]         hue_o,
  output logic [7:0]         saturation_o,
  output logic [7:0]         value_o
);
  import b2h_pkg::*;

  logic       hue_up_c, sat_up_c;
  logic [7:0] hue_d, sat_d;
  logic       done_q;
  logic [7:0] hue_q, sat_q, value_q;

  // Round up when twice the remainder passes the divisor, or equals it
  // with an odd quotient.
  function automatic logic round_up(input b2h_lane_t lane);
    logic [8:0] twice;
    logic [8:0] den;
    twice = {lane.rem[15:8], 1'b0};
    den   = {1'b0, lane.den};
    return (twice > den) || ((twice == den) && lane.quo[0]);
  endfunction

  always_comb begin
    hue_up_c = round_up(hue_lane_i);
    sat_up_c = round_up(sat_lane_i);
    hue_d = ctrl_i.hue_zero ? 8'd0 : (hue_lane_i.quo + 8'(hue_up_c));
    sat_d = ctrl_i.sat_zero ? 8'd0 : (sat_lane_i.quo + 8'(sat_up_c));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q   <= hue_d;
    sat_q   <= sat_d;
    value_q <= ctrl_i.value;
  end

  assign done_o       = done_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign value_o      = value_q;

endmodule

@@ hw/rtl/bgr_to_hsv_pixel_unit.sv @@
// BGR to HSV pixel unit: one pixel in per clock; each pixel passes two
// front-end stages, eight divider stages of one quotient bit each and
// one rounding stage. The unit never stalls, so busy stays low and
// done_o marks each result for exactly one cycle; the receiver must take
// it then. Top level; uses b2h_pkg and all submodules.
module bgr_to_hsv_pixel_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] blue_i,
  input  logic [7:0] green_i,
  input  logic [7:0] red_i,
  output logic       done_o,
  output logic [7:0] hue_o,
  output logic [7:0] saturation_o,
  output logic [7:0] value_o
);
  import b2h_pkg::*;

  logic      accept_c;
  b2h_ctrl_t ctrl_q [B2H_DIV_STAGES+1];
  b2h_lane_t hue_lane [B2H_DIV_STAGES+1];
  b2h_lane_t sat_lane [B2H_DIV_STAGES+1];

  // A new pixel transaction is taken every cycle that start is high.
  assign busy     = 1'b0;
  assign accept_c = start && !busy;

  b2h_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept_c),
    .blue_i     (blue_i),
    .green_i    (green_i),
    .red_i      (red_i),
    .ctrl_o     (ctrl_q[0]),
    .hue_lane_o (hue_lane[0]),
    .sat_lane_o (sat_lane[0])
  );

  // Divider stages for both quotients, with the side information
  // registered alongside.
  for (genvar s = 0; s < B2H_DIV_STAGES; s++) begin : g_div
    b2h_div_step u_hue_step (
      .clk_i  (clk_i),
      .lane_i (hue_lane[s]),
      .lane_o (hue_lane[s+1])
    );
    b2h_div_step u_sat_step (
      .clk_i  (clk_i),
      .lane_i (sat_lane[s]),
      .lane_o (sat_lane[s+1])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_q[s+1] <= '0;
      end else begin
        ctrl_q[s+1] <= ctrl_q[s];
      end
    end
  end

  b2h_round u_round (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl_q[B2H_DIV_STAGES]),
    .hue_lane_i   (hue_lane[B2H_DIV_STAGES]),
    .sat_lane_i   (sat_lane[B2H_DIV_STAGES]),
    .done_o       (done_o),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .value_o      (value_o)
  );

endmodule

@@ hw/rtl/b2h_checker.sv @@
// Port-level checker for the BGR to HSV pixel unit and its bind statement.
// Uses b2h_pkg for the pipeline latency.
module b2h_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [7:0] hue_o,
  input logic [7:0] saturation_o,
  input logic [7:0] value_o
);
  import b2h_pkg::*;

  // Every accepted transaction produces a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##B2H_LATENCY done_o)
    else $error("accepted pixel produced no result");

  // No result appears without a transaction accepted at the right time.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, B2H_LATENCY))
    else $error("result without an accepted pixel");

  // Hue stays within the half circle, 180 included.
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hue_o <= 8'd180))
    else $error("hue out of range");

  // A black pixel has no saturation.
  a_black_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && value_o == 8'd0) |-> (saturation_o == 8'd0))
    else $error("black pixel with nonzero saturation");

  // Zero saturation means a gray pixel, which has zero hue.
  a_gray_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturation_o == 8'd0) |-> (hue_o == 8'd0))
    else $error("gray pixel with nonzero hue");

endmodule

bind bgr_to_hsv_pixel_unit b2h_checker u_b2h_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .hue_o        (hue_o),
  .saturation_o (saturation_o),
  .value_o      (value_o)
);
